// ===== hw/rtl/tcspq_pkg.sv =====
// Shared types, codes and default sizes for the three-class priority queue.
`default_nettype none

package tcspq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TAG_WIDTH_DEF   = 32;
  localparam int unsigned NUM_CLASS       = 3;

  // fixed port widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned TAG_IO_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned ORDER_W  = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_SERVE   = 2'd1,
    ACT_DRAIN   = 2'd2,
    ACT_UNUSED  = 2'd3
  } tcspq_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_SERVED  = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } tcspq_status_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_EMERG = 2'd0,
    CLS_PASS  = 2'd1,
    CLS_CARGO = 2'd2
  } tcspq_class_e;

  // controller to datapath
  typedef struct packed {
    logic enq;        // enqueue the input beat's tag
    logic serve;      // single serve
    logic drain_pop;  // one pop of a drain run
    logic clr_order;  // start of a drain run
    logic load;       // capture a result into the output register
  } tcspq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic any_waiting;
    logic last_item;  // the next pop empties all queues
  } tcspq_stat_t;

endpackage : tcspq_pkg

`default_nettype wire

// ===== hw/rtl/tcspq_ctrl.sv =====
// Controller: accepts input beats, sequences drain runs, owns the output valid.
`default_nettype none

module tcspq_ctrl
  import tcspq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  input  wire tcspq_stat_t         stat_i,
  output tcspq_cmd_t               cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   acc;

  // the output register may be refilled when empty or being taken this cycle
  assign slot_free = !out_valid_q || !out_stall_i;
  assign acc       = (state_q == S_IDLE) && in_valid_i && slot_free;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = !slot_free;
        if (acc) begin
          case (tcspq_action_e'(action_i))
            ACT_ENQUEUE: begin
              cmd_o.enq  = 1'b1;
              cmd_o.load = 1'b1;
            end
            ACT_SERVE: begin
              cmd_o.serve = 1'b1;
              cmd_o.load  = 1'b1;
            end
            ACT_DRAIN: begin
              if (stat_i.any_waiting) begin
                cmd_o.clr_order = 1'b1;
                state_d         = S_DRAIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        if (slot_free) begin
          cmd_o.drain_pop = 1'b1;
          cmd_o.load      = 1'b1;
          if (stat_i.last_item) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.load)
    else $error("result register loaded while its beat is still stalled");

  a_drain_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> in_stall_o)
    else $error("input not stalled during a drain run");

  a_empty_drain_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && action_i == ACT_DRAIN && !stat_i.any_waiting) |=> (state_q == S_IDLE))
    else $error("drain of empty queues entered the drain state");

endmodule : tcspq_ctrl

`default_nettype wire

// ===== hw/rtl/tcspq_dp.sv =====
// Datapath: three circular tag FIFOs, priority pop select and the result register.
`default_nettype none

module tcspq_dp
  import tcspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_WIDTH   = TAG_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tcspq_cmd_t          cmd_i,
  output tcspq_stat_t              stat_o,
  input  wire logic [CODE_W-1:0]   class_code_i,
  input  wire logic [TAG_IO_W-1:0] item_tag_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [TAG_IO_W-1:0]      served_tag_o,
  output logic [CLASS_W-1:0]       served_class_o,
  output logic [ORDER_W-1:0]       order_number_o,
  output logic                     last_of_run_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OW = $clog2(3 * QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C    = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_X    = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX_C = IW'(QUEUE_DEPTH - 1);

  localparam logic [CODE_W-1:0] CHR_E_UP = 8'h45;
  localparam logic [CODE_W-1:0] CHR_E_LO = 8'h65;
  localparam logic [CODE_W-1:0] CHR_P_UP = 8'h50;
  localparam logic [CODE_W-1:0] CHR_P_LO = 8'h70;
  localparam logic [CODE_W-1:0] CHR_C_UP = 8'h43;
  localparam logic [CODE_W-1:0] CHR_C_LO = 8'h63;

  logic [TAG_WIDTH-1:0] store_q [NUM_CLASS][QUEUE_DEPTH];
  logic [IW-1:0]        head_q  [NUM_CLASS];
  logic [IW-1:0]        head_d  [NUM_CLASS];
  logic [CW-1:0]        count_q [NUM_CLASS];
  logic [CW-1:0]        count_d [NUM_CLASS];
  logic [OW-1:0]        order_q, order_d;

  tcspq_class_e enq_cls, pop_cls;
  logic         enq_known, enq_full;
  logic         any_waiting, pop_last;
  logic         do_write, do_pop;
  logic [CW:0]  wr_sum;
  logic [IW-1:0] wr_idx;

  // result register
  logic [STATUS_W-1:0] status_q;
  logic [TAG_IO_W-1:0] tag_q;
  logic [CLASS_W-1:0]  class_q;
  logic [ORDER_W-1:0]  order_out_q;
  logic                last_q;

  tcspq_status_e res_status;
  tcspq_class_e  res_cls;
  logic [OW-1:0] res_order;
  logic          res_last, res_served;

  // class letter, either case
  always_comb begin
    enq_known = 1'b1;
    case (class_code_i)
      CHR_E_UP, CHR_E_LO: enq_cls = CLS_EMERG;
      CHR_P_UP, CHR_P_LO: enq_cls = CLS_PASS;
      CHR_C_UP, CHR_C_LO: enq_cls = CLS_CARGO;
      default: begin
        enq_cls   = CLS_EMERG;
        enq_known = 1'b0;
      end
    endcase
  end

  assign enq_full = (count_q[enq_cls] == DEPTH_C);
  assign wr_sum   = (CW + 1)'(head_q[enq_cls]) + (CW + 1)'(count_q[enq_cls]);
  assign wr_idx   = (wr_sum >= DEPTH_X) ? IW'(wr_sum - DEPTH_X) : IW'(wr_sum);

  // strict priority: emergency, passenger, cargo
  always_comb begin
    any_waiting = 1'b1;
    if (count_q[CLS_EMERG] != '0) begin
      pop_cls  = CLS_EMERG;
      pop_last = (count_q[CLS_EMERG] == CW'(1)) && (count_q[CLS_PASS] == '0)
                 && (count_q[CLS_CARGO] == '0);
    end else if (count_q[CLS_PASS] != '0) begin
      pop_cls  = CLS_PASS;
      pop_last = (count_q[CLS_PASS] == CW'(1)) && (count_q[CLS_CARGO] == '0);
    end else begin
      pop_cls     = CLS_CARGO;
      pop_last    = (count_q[CLS_CARGO] == CW'(1));
      any_waiting = (count_q[CLS_CARGO] != '0);
    end
  end

  assign stat_o.any_waiting = any_waiting;
  assign stat_o.last_item   = pop_last;

  assign do_write = cmd_i.enq && enq_known && !enq_full;
  assign do_pop   = (cmd_i.serve || cmd_i.drain_pop) && any_waiting;

  always_comb begin
    for (int c = 0; c < NUM_CLASS; c++) begin
      head_d[c]  = head_q[c];
      count_d[c] = count_q[c];
    end
    if (do_write) begin
      count_d[enq_cls] = count_q[enq_cls] + CW'(1);
    end
    if (do_pop) begin
      count_d[pop_cls] = count_q[pop_cls] - CW'(1);
      head_d[pop_cls]  = (head_q[pop_cls] == LAST_IDX_C) ? '0 : head_q[pop_cls] + IW'(1);
    end
  end

  always_comb begin
    order_d = order_q;
    if (cmd_i.clr_order) begin
      order_d = '0;
    end else if (cmd_i.drain_pop) begin
      order_d = order_q + OW'(1);
    end
  end

  // result fields
  always_comb begin
    res_status = ST_EMPTY;
    res_cls    = CLS_EMERG;
    res_order  = '0;
    res_last   = 1'b1;
    res_served = 1'b0;
    if (cmd_i.enq) begin
      if (!enq_known) begin
        res_status = ST_UNKNOWN;
      end else begin
        res_cls    = enq_cls;
        res_status = enq_full ? ST_FULL : ST_ADDED;
      end
    end else if (any_waiting) begin
      res_status = ST_SERVED;
      res_cls    = pop_cls;
      res_served = 1'b1;
      if (cmd_i.drain_pop) begin
        res_order = order_q + OW'(1);
        res_last  = pop_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASS; c++) begin
        head_q[c]  <= '0;
        count_q[c] <= '0;
      end
      order_q <= '0;
    end else begin
      for (int c = 0; c < NUM_CLASS; c++) begin
        head_q[c]  <= head_d[c];
        count_q[c] <= count_d[c];
      end
      order_q <= order_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      store_q[enq_cls][wr_idx] <= TAG_WIDTH'(item_tag_i);
    end
  end

  // head entry read straight into the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q    <= res_status;
      class_q     <= res_cls;
      order_out_q <= ORDER_W'(res_order);
      last_q      <= res_last;
      tag_q       <= res_served ? TAG_IO_W'(store_q[pop_cls][head_q[pop_cls]]) : '0;
    end
  end

  assign status_o       = status_q;
  assign served_tag_o   = tag_q;
  assign served_class_o = class_q;
  assign order_number_o = order_out_q;
  assign last_of_run_o  = last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[CLS_EMERG] <= DEPTH_C && count_q[CLS_PASS] <= DEPTH_C
    && count_q[CLS_CARGO] <= DEPTH_C)
    else $error("queue fill level beyond depth");

  a_one_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.enq && (cmd_i.serve || cmd_i.drain_pop)))
    else $error("enqueue and pop commanded together");

  a_last_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && pop_last) |=> !any_waiting)
    else $error("items left after the pop flagged as last");

endmodule : tcspq_dp

`default_nettype wire

// ===== hw/rtl/three_class_strict_priority_queue_top.sv =====
// Top level of the three-class strict priority queue.
`default_nettype none

// Three FIFOs of QUEUE_DEPTH tags (emergency, passenger, cargo), served in
// strict priority order. Every input beat with action enqueue or serve gives
// one result beat, and these run at one beat per cycle while the output side
// keeps taking results; the next input beat is taken in the cycle that the
// waiting result leaves the output register, and a stalled result stalls the
// input. A drain takes the input beat, stalls the input, then pops one item
// per cycle while the output side keeps taking results (one output beat each,
// numbered from 1, the final one flagged) until no items are waiting. A drain
// with nothing waiting and action code three give no result. A full queue or
// an unknown class letter is reported and changes nothing. Tags are stored
// TAG_WIDTH bits wide.

module three_class_strict_priority_queue_top
  import tcspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_WIDTH   = TAG_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [CODE_W-1:0]   class_code_i,
  input  wire logic [TAG_IO_W-1:0] item_tag_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [TAG_IO_W-1:0]      served_tag_o,
  output logic [CLASS_W-1:0]       served_class_o,
  output logic [ORDER_W-1:0]       order_number_o,
  output logic                     last_of_run_o
);

  tcspq_cmd_t  cmd;
  tcspq_stat_t stat;

  tcspq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcspq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .class_code_i   (class_code_i),
    .item_tag_i     (item_tag_i),
    .status_o       (status_o),
    .served_tag_o   (served_tag_o),
    .served_class_o (served_class_o),
    .order_number_o (order_number_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule : three_class_strict_priority_queue_top

`default_nettype wire

// ===== dv/tcspq_checker.sv =====
// Result checker for the three-class priority queue: predicts every result beat and compares it.
`timescale 1ns / 100ps

package tcspq_tb_pkg;

  // class letters, matched in either case
  localparam logic [tcspq_pkg::CODE_W-1:0] LETTER_E_UP = "E";
  localparam logic [tcspq_pkg::CODE_W-1:0] LETTER_E_LO = "e";
  localparam logic [tcspq_pkg::CODE_W-1:0] LETTER_P_UP = "P";
  localparam logic [tcspq_pkg::CODE_W-1:0] LETTER_P_LO = "p";
  localparam logic [tcspq_pkg::CODE_W-1:0] LETTER_C_UP = "C";
  localparam logic [tcspq_pkg::CODE_W-1:0] LETTER_C_LO = "c";

endpackage : tcspq_tb_pkg

module tcspq_checker
  import tcspq_pkg::*;
  import tcspq_tb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [CODE_W-1:0]   class_code_i,
  input  logic [TAG_IO_W-1:0] item_tag_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [TAG_IO_W-1:0] served_tag_i,
  input  logic [CLASS_W-1:0]  served_class_i,
  input  logic [ORDER_W-1:0]  order_number_i,
  input  logic                last_of_run_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    tcspq_status_e       status;
    logic [TAG_IO_W-1:0] tag;
    logic [CLASS_W-1:0]  cls;
    logic [ORDER_W-1:0]  order;
    logic                last;
  } result_t;

  logic [TAG_IO_W-1:0] lane_store [NUM_CLASS][DEPTH];
  int                  lane_head  [NUM_CLASS];
  int                  lane_fill  [NUM_CLASS];
  result_t             due_results [$];

  function automatic int lane_of(input logic [CODE_W-1:0] code);
    if (code == LETTER_E_UP || code == LETTER_E_LO) return int'(CLS_EMERG);
    if (code == LETTER_P_UP || code == LETTER_P_LO) return int'(CLS_PASS);
    if (code == LETTER_C_UP || code == LETTER_C_LO) return int'(CLS_CARGO);
    return -1;
  endfunction

  // pops the head of the highest-priority non-empty lane
  function automatic bit pop_top(output int lane, output logic [TAG_IO_W-1:0] tag);
    int c;
    lane = 0;
    tag  = '0;
    for (c = 0; c < NUM_CLASS; c++) begin
      if (lane_fill[c] != 0) begin
        lane = c;
        tag  = lane_store[c][lane_head[c]];
        lane_head[c] = (lane_head[c] + 1) % DEPTH;
        lane_fill[c]--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_beat(input logic [ACTION_W-1:0] act, input logic [CODE_W-1:0] code,
                              input logic [TAG_IO_W-1:0] tag);
    result_t             r;
    int                  lane;
    int                  n;
    logic [TAG_IO_W-1:0] t;
    r      = '0;
    r.last = 1'b1;
    case (tcspq_action_e'(act))
      ACT_ENQUEUE: begin
        lane = lane_of(code);
        if (lane < 0) begin
          r.status = ST_UNKNOWN;
        end else if (lane_fill[lane] >= DEPTH) begin
          r.status = ST_FULL;
          r.cls    = lane[CLASS_W-1:0];
        end else begin
          lane_store[lane][(lane_head[lane] + lane_fill[lane]) % DEPTH] = tag;
          lane_fill[lane]++;
          r.status = ST_ADDED;
          r.cls    = lane[CLASS_W-1:0];
        end
        due_results.push_back(r);
      end
      ACT_SERVE: begin
        if (pop_top(lane, t)) begin
          r.status = ST_SERVED;
          r.tag    = t;
          r.cls    = lane[CLASS_W-1:0];
        end else begin
          r.status = ST_EMPTY;
        end
        due_results.push_back(r);
      end
      ACT_DRAIN: begin
        // empty queues give no beat at all
        n = 0;
        while (pop_top(lane, t)) begin
          n++;
          r.status = ST_SERVED;
          r.tag    = t;
          r.cls    = lane[CLASS_W-1:0];
          r.order  = n[ORDER_W-1:0];
          r.last   = (lane_fill[0] + lane_fill[1] + lane_fill[2] == 0);
          due_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    result_t seen;
    result_t want;
    seen.status = tcspq_status_e'(status_i);
    seen.tag    = served_tag_i;
    seen.cls    = served_class_i;
    seen.order  = order_number_i;
    seen.last   = last_of_run_i;
    if (due_results.size() == 0) begin
      $display("%0t: result beat with none due: status %0d tag %h class %0d order %0d last %0b",
               $time, seen.status, seen.tag, seen.cls, seen.order, seen.last);
      fail_count_o++;
    end else begin
      want = due_results.pop_front();
      if (seen !== want) begin
        $display("%0t: expected status %0d tag %h class %0d order %0d last %0b",
                 $time, want.status, want.tag, want.cls, want.order, want.last);
        $display("%0t:   actual status %0d tag %h class %0d order %0d last %0b",
                 $time, seen.status, seen.tag, seen.cls, seen.order, seen.last);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASS; c++) begin
        lane_head[c] = 0;
        lane_fill[c] = 0;
      end
      due_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_beat(action_i, class_code_i, item_tag_i);
      if (out_valid_i && !out_stall_i) check_result();
      pending_o = due_results.size();
    end
  end

endmodule : tcspq_checker

// ===== dv/three_class_strict_priority_queue_top_test.sv =====
// Testbench top for the three-class priority queue: stimulus, idling and the verdict.
`timescale 1ns / 100ps

module three_class_strict_priority_queue_top_test;
  import tcspq_pkg::*;
  import tcspq_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ACTION_W-1:0] action;
  logic [CODE_W-1:0]   class_code;
  logic [TAG_IO_W-1:0] item_tag;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [TAG_IO_W-1:0] served_tag;
  logic [CLASS_W-1:0]  served_class;
  logic [ORDER_W-1:0]  order_number;
  logic                last_of_run;
  int                  fail_count;
  int                  pending;
  int                  cycle_count = 0;
  int                  items_sent;
  bit                  calm;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  three_class_strict_priority_queue_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .class_code_i   (class_code),
    .item_tag_i     (item_tag),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .served_tag_o   (served_tag),
    .served_class_o (served_class),
    .order_number_o (order_number),
    .last_of_run_o  (last_of_run)
  );

  tcspq_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (action),
    .class_code_i   (class_code),
    .item_tag_i     (item_tag),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .served_tag_i   (served_tag),
    .served_class_i (served_class),
    .order_number_i (order_number),
    .last_of_run_i  (last_of_run),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("three_class_strict_priority_queue_top: mismatch");
      $finish;
    end
  end

  // result side: runs of taking beats broken by stalls, mostly short
  initial begin : result_side
    int unsigned span;
    bit          hold;
    out_stall = 1'b0;
    forever begin
      hold = ($urandom_range(0, 2) == 0);
      if (hold) span = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      else span = $urandom_range(1, 24);
      repeat (span) begin
        @(negedge clk);
        out_stall <= hold;
      end
    end
  end

  task automatic send_beat(input tcspq_action_e act, input logic [CODE_W-1:0] code,
                           input logic [TAG_IO_W-1:0] tag);
    int unsigned idle;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) idle = 0;
    else if (roll < 85) idle = $urandom_range(1, 3);
    else if (roll < 95) idle = $urandom_range(4, 8);
    else idle = $urandom_range(10, 30);
    repeat (idle) begin
      @(negedge clk);
      in_valid   <= 1'b0;
      action     <= ACTION_W'($urandom);
      class_code <= CODE_W'($urandom);
      item_tag   <= $urandom;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    action     <= act;
    class_code <= code;
    item_tag   <= tag;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // serve, drain or the unused code, with junk in the fields they ignore
  task automatic send_op(input tcspq_action_e act);
    send_beat(act, CODE_W'($urandom), $urandom);
  endtask

  task automatic enqueue(input tcspq_class_e lane);
    logic [CODE_W-1:0] letter;
    bit                lower;
    lower = ($urandom_range(0, 1) == 1);
    case (lane)
      CLS_EMERG: letter = lower ? LETTER_E_LO : LETTER_E_UP;
      CLS_PASS:  letter = lower ? LETTER_P_LO : LETTER_P_UP;
      default:   letter = lower ? LETTER_C_LO : LETTER_C_UP;
    endcase
    send_beat(ACT_ENQUEUE, letter, $urandom);
  endtask

  initial begin : stimulus
    int unsigned       kind;
    int unsigned       roll;
    int                c;
    logic [CODE_W-1:0] odd_code;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    action     = ACT_ENQUEUE;
    class_code = '0;
    item_tag   = '0;
    calm       = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty queues, every letter in both cases, tag extremes, stray bytes
    send_op(ACT_SERVE);
    send_op(ACT_DRAIN);
    send_beat(ACT_UNUSED, LETTER_E_UP, '1);
    send_beat(ACT_ENQUEUE, LETTER_C_UP, 32'h0000_0000);
    send_beat(ACT_ENQUEUE, LETTER_C_LO, 32'hFFFF_FFFF);
    send_beat(ACT_ENQUEUE, LETTER_P_UP, 32'hA5A5_A5A5);
    send_beat(ACT_ENQUEUE, LETTER_P_LO, 32'h5A5A_5A5A);
    send_beat(ACT_ENQUEUE, LETTER_E_UP, 32'h8000_0001);
    send_beat(ACT_ENQUEUE, LETTER_E_LO, 32'h7FFF_FFFE);
    send_beat(ACT_ENQUEUE, 8'h00, 32'h1234_5678);
    send_beat(ACT_ENQUEUE, 8'hFF, 32'hFFFF_FFFF);
    send_beat(ACT_ENQUEUE, 8'h44, 32'h0000_0001);
    send_beat(ACT_ENQUEUE, 8'hC5, 32'h0000_0002);
    send_op(ACT_SERVE);
    send_op(ACT_SERVE);
    send_op(ACT_DRAIN);
    send_op(ACT_SERVE);
    send_beat(ACT_UNUSED, LETTER_P_LO, '0);

    while (items_sent < 225) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          // one lane toward full and often past it
          c = $urandom_range(0, 2);
          repeat ($urandom_range(12, 20)) enqueue(tcspq_class_e'(c));
        end
        2: begin
          // every lane full, then the longest drain
          for (c = 0; c < NUM_CLASS; c++) begin
            repeat ($urandom_range(16, 18)) enqueue(tcspq_class_e'(c));
          end
          send_op(ACT_DRAIN);
        end
        7, 8: repeat ($urandom_range(3, 10)) send_op(ACT_SERVE);
        9: send_op(ACT_DRAIN);
        default: begin
          repeat ($urandom_range(4, 12)) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
              enqueue(tcspq_class_e'($urandom_range(0, 2)));
            end else if (roll < 75) begin
              send_op(ACT_SERVE);
            end else if (roll < 83) begin
              do odd_code = CODE_W'($urandom);
              while (odd_code == LETTER_E_UP || odd_code == LETTER_E_LO ||
                     odd_code == LETTER_P_UP || odd_code == LETTER_P_LO ||
                     odd_code == LETTER_C_UP || odd_code == LETTER_C_LO);
              send_beat(ACT_ENQUEUE, odd_code, $urandom);
            end else if (roll < 90) begin
              send_op(ACT_DRAIN);
            end else if (roll < 95) begin
              send_op(ACT_UNUSED);
            end else begin
              send_beat(tcspq_action_e'($urandom_range(0, 3)), CODE_W'($urandom), $urandom);
            end
          end
        end
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // settle: any beat beyond those due is flagged by the checker
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("three_class_strict_priority_queue_top: match");
    end else begin
      $display("three_class_strict_priority_queue_top: mismatch");
    end
    $finish;
  end

endmodule : three_class_strict_priority_queue_top_test
